/* hw/rtl/jtcc_pkg.sv */
// Package with the types and codes shared by the time claim checker modules.
package jtcc_pkg;

  localparam logic [2:0] VERDICT_OK        = 3'd0;
  localparam logic [2:0] VERDICT_NO_DOT    = 3'd1;
  localparam logic [2:0] VERDICT_BAD_LOAD  = 3'd2;
  localparam logic [2:0] VERDICT_NOT_YET   = 3'd3;
  localparam logic [2:0] VERDICT_EXPIRED   = 3'd4;

  localparam logic [15:0] MARGIN_RESET = 16'd60;

  localparam logic [1:0] SEG_HEADER  = 2'd0;
  localparam logic [1:0] SEG_PAYLOAD = 2'd1;
  localparam logic [1:0] SEG_TAIL    = 2'd2;

  localparam logic [3:0] PH_SPACE  = 4'd6;
  localparam logic [3:0] PH_NUMBER = 4'd7;
  localparam logic [3:0] PH_DONE   = 4'd8;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [63:0] MAX_I64 = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [5:0][7:0] NBF_KEY = {8'h3A, 8'h22, 8'h66, 8'h62, 8'h6E, 8'h22};
  localparam logic [5:0][7:0] EXP_KEY = {8'h3A, 8'h22, 8'h70, 8'h78, 8'h65, 8'h22};

  typedef struct packed {
    logic [7:0]         token_char;
    logic               last_char;
    logic signed [63:0] now_epoch;
  } in_t;

  typedef struct packed {
    logic       token_valid;
    logic [2:0] verdict;
  } out_t;

  typedef struct packed {
    logic [7:0]         token_byte;
    logic               has_byte;
    logic               last;
    logic               seg_ok;
    logic               bad_empty;
    logic signed [63:0] now_epoch;
  } mid_t;

endpackage

/* hw/rtl/jtcc_front.sv */
// Front part: segment tracking, base64url and standard base64 decoding and the queue to the back part.
module jtcc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  jtcc_pkg::in_t in_data,
  output logic          head_valid,
  output jtcc_pkg::mid_t head,
  input  logic          head_pop
);

  logic [1:0]  seg_r, seg_nxt;
  logic [12:0] buf_r, buf_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        stop_r, stop_nxt, bad_r, bad_nxt, seen_r, seen_nxt;
  logic        accept, byte_ev;
  logic [5:0]  sextet;
  logic        sx_ok;
  logic [7:0]  c;
  logic [12:0] shifted;

  jtcc_pkg::mid_t q_mem_r [2];
  logic [1:0] q_cnt_r;
  logic       q_wp_r, q_rp_r;
  logic       q_push;

  assign c = in_data.token_char;
  assign accept = in_push && !in_full;

  always_comb begin
    sx_ok = 1'b1;
    sextet = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B || c == 8'h2D) begin
      sextet = 6'd62;
    end else if (c == 8'h2F || c == 8'h5F) begin
      sextet = 6'd63;
    end else begin
      sx_ok = 1'b0;
    end
  end

  always_comb begin
    seg_nxt = seg_r;
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    stop_nxt = stop_r;
    bad_nxt = bad_r;
    seen_nxt = seen_r;
    byte_ev = 1'b0;
    shifted = 13'd0;
    if (seg_r == jtcc_pkg::SEG_HEADER) begin
      if (c == jtcc_pkg::CH_DOT) seg_nxt = jtcc_pkg::SEG_PAYLOAD;
    end else if (seg_r == jtcc_pkg::SEG_PAYLOAD) begin
      if (c == jtcc_pkg::CH_DOT) begin
        seg_nxt = jtcc_pkg::SEG_TAIL;
      end else if (!stop_r && !bad_r) begin
        if (c == jtcc_pkg::CH_PAD) begin
          stop_nxt = 1'b1;
        end else if (!sx_ok) begin
          bad_nxt = 1'b1;
        end else begin
          buf_nxt = {buf_r[6:0], sextet};
          cnt_nxt = cnt_r + 4'd6;
          if (cnt_nxt >= 4'd8) begin
            cnt_nxt = cnt_nxt - 4'd8;
            byte_ev = 1'b1;
            seen_nxt = 1'b1;
            shifted = buf_nxt >> cnt_nxt;
          end
        end
      end
    end
  end

  assign q_push = accept && (byte_ev || in_data.last_char);
  assign in_full = (q_cnt_r == 2'd2);
  assign head_valid = (q_cnt_r != 2'd0);
  assign head = q_mem_r[q_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= jtcc_pkg::SEG_HEADER;
      buf_r <= 13'd0;
      cnt_r <= 4'd0;
      stop_r <= 1'b0;
      bad_r <= 1'b0;
      seen_r <= 1'b0;
    end else if (accept) begin
      if (in_data.last_char) begin
        seg_r <= jtcc_pkg::SEG_HEADER;
        buf_r <= 13'd0;
        cnt_r <= 4'd0;
        stop_r <= 1'b0;
        bad_r <= 1'b0;
        seen_r <= 1'b0;
      end else begin
        seg_r <= seg_nxt;
        buf_r <= buf_nxt;
        cnt_r <= cnt_nxt;
        stop_r <= stop_nxt;
        bad_r <= bad_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
      q_wp_r <= 1'b0;
      q_rp_r <= 1'b0;
    end else begin
      if (q_push) q_wp_r <= !q_wp_r;
      if (head_pop) q_rp_r <= !q_rp_r;
      q_cnt_r <= q_cnt_r + {1'b0, q_push} - {1'b0, head_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[q_wp_r].token_byte <= shifted[7:0];
      q_mem_r[q_wp_r].has_byte <= byte_ev;
      q_mem_r[q_wp_r].last <= in_data.last_char;
      q_mem_r[q_wp_r].seg_ok <= seg_nxt[1];
      q_mem_r[q_wp_r].bad_empty <= bad_nxt || !seen_nxt;
      q_mem_r[q_wp_r].now_epoch <= in_data.now_epoch;
    end
  end

endmodule

/* hw/rtl/jtcc_matcher.sv */
// Key matcher and saturating decimal parser for one time claim.
module jtcc_matcher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [5:0][7:0]    key,
  input  logic               feed,
  input  logic [7:0]         c,
  input  logic               clear,
  output logic               present_nxt,
  output logic signed [63:0] value_nxt
);

  logic [3:0]  ph_r, ph_nxt;
  logic [63:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt, dig_r, dig_nxt;
  logic        is_space, is_digit, to_number;
  logic [67:0] prod;

  assign is_space = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  assign is_digit = (c >= 8'h30 && c <= 8'h39);
  assign prod = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + {60'd0, 8'(c - 8'h30)};

  always_comb begin
    ph_nxt = ph_r;
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    dig_nxt = dig_r;
    to_number = 1'b0;
    if (feed) begin
      if (ph_r < 4'd6) begin
        if (c == key[ph_r[2:0]]) ph_nxt = ph_r + 4'd1;
        else if (ph_r == 4'd5 && c == key[1]) ph_nxt = 4'd2;
        else if (c == key[0]) ph_nxt = 4'd1;
        else ph_nxt = 4'd0;
      end else if (ph_r == jtcc_pkg::PH_SPACE) begin
        if (c == jtcc_pkg::CH_MINUS) begin
          neg_nxt = 1'b1;
          ph_nxt = jtcc_pkg::PH_NUMBER;
        end else if (!is_space) begin
          to_number = 1'b1;
        end
      end else if (ph_r == jtcc_pkg::PH_NUMBER) begin
        to_number = 1'b1;
      end
      if (to_number) begin
        if (is_digit) begin
          mag_nxt = (prod > {4'd0, jtcc_pkg::MAX_I64}) ? jtcc_pkg::MAX_I64 : prod[63:0];
          dig_nxt = 1'b1;
          ph_nxt = jtcc_pkg::PH_NUMBER;
        end else begin
          ph_nxt = jtcc_pkg::PH_DONE;
        end
      end
    end
  end

  assign present_nxt = dig_nxt;
  assign value_nxt = neg_nxt ? -$signed(mag_nxt) : $signed(mag_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      ph_r <= 4'd0;
      mag_r <= 64'd0;
      neg_r <= 1'b0;
      dig_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      mag_r <= mag_nxt;
      neg_r <= neg_nxt;
      dig_r <= dig_nxt;
    end
  end

endmodule

/* hw/rtl/jtcc_back.sv */
// Back part: claim matchers, verdict stage and result queue.
module jtcc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  jtcc_pkg::mid_t head,
  output logic           head_pop,
  input  logic [15:0]    margin,
  output logic           out_empty,
  input  logic           out_pop,
  output jtcc_pkg::out_t out_data
);

  logic               feed, clr, b_ready, o_push;
  logic               nbf_p, exp_p;
  logic signed [63:0] nbf_v, exp_v;
  logic               b_valid_r, b_seg_r, b_bad_r, b_nbf_p_r, b_exp_p_r;
  logic signed [63:0] b_nbf_r, b_exp_r, b_now_r;
  logic signed [64:0] sum;
  logic [2:0]         verdict;
  jtcc_pkg::out_t     o_mem_r [2];
  logic [1:0]         o_cnt_r;
  logic               o_wp_r, o_rp_r, o_pop;

  assign o_push = b_valid_r && (o_cnt_r != 2'd2);
  assign b_ready = !b_valid_r || o_push;
  assign head_pop = head_valid && (!head.last || b_ready);
  assign feed = head_pop && head.has_byte;
  assign clr = head_pop && head.last;

  jtcc_matcher u_nbf (
    .clk(clk), .rst_n(rst_n), .key(jtcc_pkg::NBF_KEY), .feed(feed), .c(head.token_byte),
    .clear(clr), .present_nxt(nbf_p), .value_nxt(nbf_v)
  );

  jtcc_matcher u_exp (
    .clk(clk), .rst_n(rst_n), .key(jtcc_pkg::EXP_KEY), .feed(feed), .c(head.token_byte),
    .clear(clr), .present_nxt(exp_p), .value_nxt(exp_v)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (clr) begin
      b_valid_r <= 1'b1;
    end else if (o_push) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      b_seg_r <= head.seg_ok;
      b_bad_r <= head.bad_empty;
      b_nbf_p_r <= nbf_p;
      b_exp_p_r <= exp_p;
      b_nbf_r <= nbf_v;
      b_exp_r <= exp_v;
      b_now_r <= head.now_epoch;
    end
  end

  assign sum = {b_now_r[63], b_now_r} + $signed({49'd0, margin});

  always_comb begin
    verdict = jtcc_pkg::VERDICT_OK;
    if (!b_seg_r) begin
      verdict = jtcc_pkg::VERDICT_NO_DOT;
    end else if (b_bad_r) begin
      verdict = jtcc_pkg::VERDICT_BAD_LOAD;
    end else if (b_nbf_p_r && (b_nbf_r > b_now_r)) begin
      verdict = jtcc_pkg::VERDICT_NOT_YET;
    end else if (b_exp_p_r && ($signed({b_exp_r[63], b_exp_r}) <= sum)) begin
      verdict = jtcc_pkg::VERDICT_EXPIRED;
    end
  end

  assign o_pop = out_pop && !out_empty;
  assign out_empty = (o_cnt_r == 2'd0);
  assign out_data = o_mem_r[o_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_cnt_r <= 2'd0;
      o_wp_r <= 1'b0;
      o_rp_r <= 1'b0;
    end else begin
      if (o_push) o_wp_r <= !o_wp_r;
      if (o_pop) o_rp_r <= !o_rp_r;
      o_cnt_r <= o_cnt_r + {1'b0, o_push} - {1'b0, o_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) begin
      o_mem_r[o_wp_r].verdict <= verdict;
      o_mem_r[o_wp_r].token_valid <= (verdict == jtcc_pkg::VERDICT_OK);
    end
  end

endmodule

/* hw/rtl/jwt_time_claim_checker_unit.sv */
// Top level of the streaming token time claim checker.
// Throughput is one character per cycle while results are taken as they appear.
// A verdict reaches the result ports after the last character is transferred, passing
// through the front queue, the verdict stage with the matcher step folded in, and the result queue.
// Synchronous reset clears the token parsing state, empties both queues and sets the margin register to 60.
module jwt_time_claim_checker_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  jtcc_pkg::in_t  in_data,
  output logic           out_empty,
  input  logic           out_pop,
  output jtcc_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    cfg_data
);

  logic           head_valid, head_pop;
  jtcc_pkg::mid_t head;
  logic [15:0]    margin_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= jtcc_pkg::MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      margin_r <= cfg_data;
    end
  end

  jtcc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .head_valid(head_valid), .head(head), .head_pop(head_pop)
  );

  jtcc_back u_back (
    .clk(clk), .rst_n(rst_n), .head_valid(head_valid), .head(head), .head_pop(head_pop),
    .margin(margin_r), .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

endmodule

/* hw/rtl/jtcc_checker.sv */
// Port-level checker for the time claim checker, bound to the top level.
module jtcc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_full,
  input logic           out_empty,
  input logic           out_pop,
  input jtcc_pkg::out_t out_data
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("block not idle after reset");

  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_data.verdict <= jtcc_pkg::VERDICT_EXPIRED)
    else $error("verdict code out of range");

  a_valid_matches: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_data.token_valid == (out_data.verdict == jtcc_pkg::VERDICT_OK))
    else $error("token_valid disagrees with verdict");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed before transfer");

endmodule

bind jwt_time_claim_checker_unit jtcc_checker u_jtcc_checker (
  .clk(clk), .rst_n(rst_n), .in_full(in_full), .out_empty(out_empty),
  .out_pop(out_pop), .out_data(out_data)
);
